>>> hw/rtl/julia_escape_time_core_macros.svh
// ----------------------------------------------------------------------------
// julia escape time core assertion macros
// implication checks on the rising edge of clk, off while rst_n is low
// ----------------------------------------------------------------------------
`ifndef JULIA_ESCAPE_TIME_CORE_MACROS_SVH
`define JULIA_ESCAPE_TIME_CORE_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define JET_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("jet: same-cycle check failed");
// next-cycle implication
`define JET_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("jet: next-cycle check failed");
`else
`define JET_ASSERT_IMP(lbl, ante, cons)
`define JET_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

>>> hw/rtl/jet_pkg.sv
// ----------------------------------------------------------------------------
// jet_pkg
// shared types, constants and helpers of the julia escape time core
// ----------------------------------------------------------------------------
package jet_pkg;

  localparam int PIX_W  = 10;
  localparam int FIX_W  = 32;
  localparam int SCL_W  = 31;
  localparam int ITER_W = 16;
  localparam int FRAC_W = 28;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = 1;

  // |z|^2 >= 4 in Q8.56
  localparam logic [63:0] ESC_LIMIT = 64'h0400_0000_0000_0000;

  localparam logic signed [FIX_W-1:0] C_REAL_RST     = 32'sd0;
  localparam logic signed [FIX_W-1:0] C_IMAG_RST     = 32'sd0;
  localparam logic [SCL_W-1:0]        SCALE_X_RST    = 31'd786432;
  localparam logic [SCL_W-1:0]        SCALE_Y_RST    = 31'd524288;
  localparam logic [ITER_W-1:0]       ITER_LIMIT_RST = 16'd64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_C_REAL     = 3'd0,
    CFG_C_IMAG     = 3'd1,
    CFG_SCALE_X    = 3'd2,
    CFG_SCALE_Y    = 3'd3,
    CFG_ITER_LIMIT = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_MUL,
    B_CMB,
    B_UPD
  } back_state_t;

  typedef struct packed {
    logic [PIX_W-1:0]        px;
    logic [PIX_W-1:0]        py;
    logic signed [FIX_W-1:0] zx;
    logic signed [FIX_W-1:0] zy;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // clamp to the signed 32-bit range
  function automatic logic signed [FIX_W-1:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sh0000_0000_7fff_ffff;
    lo = -64'sh0000_0000_8000_0000;
    if (v > hi) begin
      return 32'sh7fff_ffff;
    end else if (v < lo) begin
      return -32'sh8000_0000;
    end
    return v[FIX_W-1:0];
  endfunction

endpackage

>>> hw/rtl/jet_queue.sv
// ----------------------------------------------------------------------------
// jet_queue
// short register queue carrying start points from the front to the back
// ----------------------------------------------------------------------------
module jet_queue
  import jet_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t wr_entry,
  input  logic     pop,
  output q_entry_t rd_entry,
  output q_stat_t  stat
);

  q_entry_t        mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r;
  logic [Q_AW-1:0] rd_ptr_r;
  logic [Q_AW:0]   cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_entry;
    end
  end

  assign rd_entry   = mem_r[rd_ptr_r];
  assign stat.full  = (cnt_r == (Q_AW+1)'(Q_DEPTH));
  assign stat.empty = (cnt_r == '0);

endmodule

>>> hw/rtl/jet_front.sv
// ----------------------------------------------------------------------------
// jet_front
// takes a pixel, maps it to its start point z0 and queues it
// ----------------------------------------------------------------------------
module jet_front
  import jet_pkg::*;
#(
  parameter int IMG_WIDTH  = 1024,
  parameter int IMG_HEIGHT = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [PIX_W-1:0] pixel_x,
  input  logic [PIX_W-1:0] pixel_y,
  input  logic [SCL_W-1:0] scale_x,
  input  logic [SCL_W-1:0] scale_y,
  input  q_stat_t          q_stat,
  output logic             q_push,
  output q_entry_t         q_entry
);

  localparam int CLW_X = $clog2(IMG_WIDTH);
  localparam int CLW_Y = $clog2(IMG_HEIGHT);
  localparam int DXW   = ((PIX_W > CLW_X) ? PIX_W : CLW_X) + 1;
  localparam int DYW   = ((PIX_W > CLW_Y) ? PIX_W : CLW_Y) + 1;
  localparam int PXW   = DXW + FIX_W;
  localparam int PYW   = DYW + FIX_W;
  localparam int HALF_W = IMG_WIDTH / 2;
  localparam int HALF_H = IMG_HEIGHT / 2;

  front_state_t state_r, state_nxt;

  logic [PIX_W-1:0]      px_r;
  logic [PIX_W-1:0]      py_r;
  logic signed [DXW-1:0] dx;
  logic signed [DYW-1:0] dy;
  logic signed [FIX_W-1:0] sx;
  logic signed [FIX_W-1:0] sy;
  logic signed [PXW-1:0] prod_x_r;
  logic signed [PYW-1:0] prod_y_r;
  logic                  accept;

  assign accept = start && (state_r == F_IDLE);
  assign busy   = (state_r != F_IDLE);

  assign dx = DXW'(px_r) - DXW'(HALF_W);
  assign dy = DYW'(py_r) - DYW'(HALF_H);
  assign sx = {1'b0, scale_x};
  assign sy = {1'b0, scale_y};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      px_r <= pixel_x;
      py_r <= pixel_y;
    end
    prod_x_r <= dx * sx;
    prod_y_r <= dy * sy;
  end

  always_comb begin
    state_nxt = state_r;
    q_push    = 1'b0;
    unique case (state_r)
      F_IDLE: begin
        if (start) begin
          state_nxt = F_MUL;
        end
      end
      F_MUL: begin
        state_nxt = F_PUSH;
      end
      F_PUSH: begin
        if (!q_stat.full) begin
          q_push    = 1'b1;
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  assign q_entry.px = px_r;
  assign q_entry.py = py_r;
  assign q_entry.zx = sat32(64'(prod_x_r));
  assign q_entry.zy = sat32(64'(prod_y_r));

endmodule

>>> hw/rtl/jet_iter.sv
// ----------------------------------------------------------------------------
// jet_iter
// runs z = z*z + c on one queued start point and reports the step count
// ----------------------------------------------------------------------------
module jet_iter
  import jet_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic signed [FIX_W-1:0] c_real,
  input  logic signed [FIX_W-1:0] c_imag,
  input  logic [ITER_W-1:0]       iter_limit,
  input  q_stat_t                 q_stat,
  input  q_entry_t                q_entry,
  output logic                    q_pop,
  output logic                    out_valid,
  output logic [PIX_W-1:0]        out_x,
  output logic [PIX_W-1:0]        out_y,
  output logic [ITER_W-1:0]       out_iterations
);

  localparam int RE_W = 64 - FRAC_W;
  localparam int IM_W = 64 - FRAC_W + 1;

  back_state_t state_r, state_nxt;

  logic signed [FIX_W-1:0] zx_r;
  logic signed [FIX_W-1:0] zy_r;
  logic [PIX_W-1:0]        px_r;
  logic [PIX_W-1:0]        py_r;
  logic [ITER_W-1:0]       n_r;
  logic signed [63:0]      xx_r;
  logic signed [63:0]      yy_r;
  logic signed [63:0]      xy_r;
  logic signed [RE_W-1:0]  re_r;
  logic signed [IM_W-1:0]  im_r;
  logic [63:0]             mag;
  logic signed [63:0]      diff;
  logic                    escaped;
  logic                    emit;
  logic                    step;
  logic                    out_valid_r;
  logic [PIX_W-1:0]        out_x_r;
  logic [PIX_W-1:0]        out_y_r;
  logic [ITER_W-1:0]       out_n_r;

  assign mag     = $unsigned(xx_r) + $unsigned(yy_r);
  assign escaped = (mag >= ESC_LIMIT);
  assign diff    = xx_r - yy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= emit;
    end
  end

  // products follow z every cycle, floor shifts are plain bit selects
  always_ff @(posedge clk) begin
    xx_r <= zx_r * zx_r;
    yy_r <= zy_r * zy_r;
    xy_r <= zx_r * zy_r;
    re_r <= diff[63:FRAC_W];
    im_r <= xy_r[63:FRAC_W-1];
    if (q_pop) begin
      px_r <= q_entry.px;
      py_r <= q_entry.py;
      zx_r <= q_entry.zx;
      zy_r <= q_entry.zy;
      n_r  <= '0;
    end else if (step) begin
      zx_r <= sat32(64'(re_r) + 64'(c_real));
      zy_r <= sat32(64'(im_r) + 64'(c_imag));
      n_r  <= n_r + 1'b1;
    end
    if (emit) begin
      out_x_r <= px_r;
      out_y_r <= py_r;
      out_n_r <= n_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    emit      = 1'b0;
    step      = 1'b0;
    unique case (state_r)
      B_IDLE: begin
        if (!q_stat.empty) begin
          q_pop     = 1'b1;
          state_nxt = B_MUL;
        end
      end
      B_MUL: begin
        if (n_r >= iter_limit) begin
          emit      = 1'b1;
          state_nxt = B_IDLE;
        end else begin
          state_nxt = B_CMB;
        end
      end
      B_CMB: begin
        if (escaped) begin
          emit      = 1'b1;
          state_nxt = B_IDLE;
        end else begin
          state_nxt = B_UPD;
        end
      end
      B_UPD: begin
        step      = 1'b1;
        state_nxt = B_MUL;
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  assign out_valid      = out_valid_r;
  assign out_x          = out_x_r;
  assign out_y          = out_y_r;
  assign out_iterations = out_n_r;

endmodule

>>> hw/rtl/julia_escape_time_core.sv
// ----------------------------------------------------------------------------
// julia_escape_time_core
// Julia set escape-time counter, one pixel coordinate in, one step count out
// ----------------------------------------------------------------------------
// Usage:
//   Load c_real, c_imag, scale_x, scale_y and the iteration limit through the
//   cfg_ write port (index 0 to 4, no wait states) while the core is idle.
//   A pixel word is taken on a clock edge with start high and busy low.
//   The front registers it, maps it to z0 in its F_MUL state and pushes it
//   into a 2-entry queue from F_PUSH, so busy drops again after the push and
//   stays high while the queue is full; no new word is taken before then.
//   The back pops one start point and runs each iteration (square, escape
//   compare, add c) through its B_MUL, B_CMB and B_UPD states.
//   A pixel occupies the back until its result is emitted; only then does
//   the back return to B_IDLE and pop the next start point, and the result
//   word is registered before it shows on the outputs.
//   Each result word shows on out_x, out_y, out_iterations for one cycle with
//   out_valid high; the receiver cannot stall, so no result is ever held.
//   Reset (rst_n low, synchronous) empties the queue, idles both parts and
//   restores the register defaults.
// ----------------------------------------------------------------------------
`include "julia_escape_time_core_macros.svh"

module julia_escape_time_core
  import jet_pkg::*;
#(
  parameter int IMG_WIDTH  = 1024,
  parameter int IMG_HEIGHT = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  start,
  output logic                  busy,
  input  logic [PIX_W-1:0]      in_pixel_x,
  input  logic [PIX_W-1:0]      in_pixel_y,
  output logic                  out_valid,
  output logic [PIX_W-1:0]      out_x,
  output logic [PIX_W-1:0]      out_y,
  output logic [ITER_W-1:0]     out_iterations
);

  logic signed [FIX_W-1:0] c_real_r;
  logic signed [FIX_W-1:0] c_imag_r;
  logic [SCL_W-1:0]        scale_x_r;
  logic [SCL_W-1:0]        scale_y_r;
  logic [ITER_W-1:0]       iter_limit_r;

  logic     q_push;
  logic     q_pop;
  q_entry_t q_wr_entry;
  q_entry_t q_rd_entry;
  q_stat_t  q_stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_real_r     <= C_REAL_RST;
      c_imag_r     <= C_IMAG_RST;
      scale_x_r    <= SCALE_X_RST;
      scale_y_r    <= SCALE_Y_RST;
      iter_limit_r <= ITER_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_C_REAL:     c_real_r     <= cfg_wdata;
        CFG_C_IMAG:     c_imag_r     <= cfg_wdata;
        CFG_SCALE_X:    scale_x_r    <= cfg_wdata[SCL_W-1:0];
        CFG_SCALE_Y:    scale_y_r    <= cfg_wdata[SCL_W-1:0];
        CFG_ITER_LIMIT: iter_limit_r <= cfg_wdata[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  jet_front #(
    .IMG_WIDTH  (IMG_WIDTH),
    .IMG_HEIGHT (IMG_HEIGHT)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .pixel_x (in_pixel_x),
    .pixel_y (in_pixel_y),
    .scale_x (scale_x_r),
    .scale_y (scale_y_r),
    .q_stat  (q_stat),
    .q_push  (q_push),
    .q_entry (q_wr_entry)
  );

  jet_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_entry (q_wr_entry),
    .pop      (q_pop),
    .rd_entry (q_rd_entry),
    .stat     (q_stat)
  );

  jet_iter u_iter (
    .clk            (clk),
    .rst_n          (rst_n),
    .c_real         (c_real_r),
    .c_imag         (c_imag_r),
    .iter_limit     (iter_limit_r),
    .q_stat         (q_stat),
    .q_entry        (q_rd_entry),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_x          (out_x),
    .out_y          (out_y),
    .out_iterations (out_iterations)
  );

  // result strobe is never high back to back
  `JET_ASSERT_NXT(a_out_strobe, out_valid, !out_valid)
  // queue never overruns or underruns
  `JET_ASSERT_IMP(a_no_push_full, q_push, !q_stat.full)
  `JET_ASSERT_IMP(a_no_pop_empty, q_pop, !q_stat.empty)
  // an accepted pixel keeps the front busy next cycle
  `JET_ASSERT_NXT(a_busy_after_accept, start && !busy, busy)

endmodule

>>> dv/julia_escape_time_core_tb.sv
// ----------------------------------------------------------------------------
// julia_escape_time_core_tb
// Pixel words go in through the start/busy handshake. Every accepted word
// gets its expected escape count from an in-bench fixed-point iterator that
// mirrors the register file. Each strobed result is checked in order against
// that count. The directed tests cover the reset defaults, the iteration
// limits, saturation and unknown register indexes. They are followed by
// random frames under several register settings.
// ----------------------------------------------------------------------------
module julia_escape_time_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import jet_pkg::*;

  localparam int IMG_W = 1024;
  localparam int IMG_H = 1024;
  localparam int FRAC = 28;
  localparam int PIX_MAX = (1 << PIX_W) - 1;
  localparam int STALL_LIMIT = 800000;
  localparam int SETTLE_CYCLES = 16;
  localparam int RANDOM_PHASES = 12;
  localparam int WORDS_PER_PHASE = 80;
  localparam longint FIX_MAX = 64'sd2147483647;
  localparam longint FIX_MIN = -64'sd2147483648;
  localparam logic [63:0] ESCAPE_MAG = 64'd4 << 56;  // 4.0 in Q8.56
  localparam logic [SCL_W-1:0] DEF_STEP_X = 31'd786432;
  localparam logic [SCL_W-1:0] DEF_STEP_Y = 31'd524288;
  localparam logic [ITER_W-1:0] DEF_LIMIT = 16'd64;

  typedef struct {
    logic [PIX_W-1:0]  x;
    logic [PIX_W-1:0]  y;
    logic [ITER_W-1:0] iters;
  } pixel_count_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [PIX_W-1:0]      in_pixel_x = '0;
  logic [PIX_W-1:0]      in_pixel_y = '0;
  logic                  out_valid;
  logic [PIX_W-1:0]      out_x;
  logic [PIX_W-1:0]      out_y;
  logic [ITER_W-1:0]     out_iterations;

  // register mirror
  logic signed [FIX_W-1:0] julia_c_re = '0;
  logic signed [FIX_W-1:0] julia_c_im = '0;
  logic [SCL_W-1:0]        step_x = DEF_STEP_X;
  logic [SCL_W-1:0]        step_y = DEF_STEP_Y;
  logic [ITER_W-1:0]       iter_limit = DEF_LIMIT;

  pixel_count_t pending_counts[$];
  int           error_count = 0;
  int           idle_pct = 11;
  int           quiet_cycles = 0;

  julia_escape_time_core #(
    .IMG_WIDTH (IMG_W),
    .IMG_HEIGHT(IMG_H)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_idx       (cfg_idx),
    .cfg_wdata     (cfg_wdata),
    .start         (start),
    .busy          (busy),
    .in_pixel_x    (in_pixel_x),
    .in_pixel_y    (in_pixel_y),
    .out_valid     (out_valid),
    .out_x         (out_x),
    .out_y         (out_y),
    .out_iterations(out_iterations)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void flag_error(input string what);
    error_count++;
    if (error_count <= 10) begin
      $display("ERROR: %s", what);
    end
  endfunction

  function automatic logic signed [FIX_W-1:0] clamp_fix(input longint v);
    longint c;
    c = v;
    if (c > FIX_MAX) begin
      c = FIX_MAX;
    end else if (c < FIX_MIN) begin
      c = FIX_MIN;
    end
    return c[FIX_W-1:0];
  endfunction

  function automatic logic [ITER_W-1:0] escape_count(input logic [PIX_W-1:0] px,
                                                     input logic [PIX_W-1:0] py);
    logic signed [FIX_W-1:0] zx;
    logic signed [FIX_W-1:0] zy;
    longint                  xx;
    longint                  yy;
    longint                  xy;
    logic [63:0]             mag;
    int unsigned             steps;
    zx = clamp_fix((longint'(px) - IMG_W / 2) * longint'(step_x));
    zy = clamp_fix((longint'(py) - IMG_H / 2) * longint'(step_y));
    steps = 0;
    while (steps < iter_limit) begin
      xx = longint'(zx) * longint'(zx);
      yy = longint'(zy) * longint'(zy);
      // unsigned sum, both squares together can reach 2^63
      mag = xx;
      mag = mag + yy;
      if (mag >= ESCAPE_MAG) begin
        break;
      end
      xy = longint'(zx) * longint'(zy);
      zx = clamp_fix(((xx - yy) >>> FRAC) + longint'(julia_c_re));
      zy = clamp_fix((xy >>> (FRAC - 1)) + longint'(julia_c_im));
      steps++;
    end
    return steps[ITER_W-1:0];
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_C_REAL:     julia_c_re = data;
      CFG_C_IMAG:     julia_c_im = data;
      CFG_SCALE_X:    step_x = data[SCL_W-1:0];
      CFG_SCALE_Y:    step_y = data[SCL_W-1:0];
      CFG_ITER_LIMIT: iter_limit = data[ITER_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // unused upper data bits get random junk
  task automatic load_julia(input logic signed [FIX_W-1:0] c_re,
                            input logic signed [FIX_W-1:0] c_im,
                            input logic [SCL_W-1:0] sx, input logic [SCL_W-1:0] sy,
                            input logic [ITER_W-1:0] limit);
    write_reg(CFG_C_REAL, c_re);
    write_reg(CFG_C_IMAG, c_im);
    write_reg(CFG_SCALE_X, {1'($urandom), sx});
    write_reg(CFG_SCALE_Y, {1'($urandom), sy});
    write_reg(CFG_ITER_LIMIT, {16'($urandom), limit});
  endtask

  task automatic send_pixel(input int px, input int py);
    pixel_count_t want;
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_pixel_x <= PIX_W'(px);
    in_pixel_y <= PIX_W'(py);
    do @(posedge clk); while (busy);
    want.x = PIX_W'(px);
    want.y = PIX_W'(py);
    want.iters = escape_count(PIX_W'(px), PIX_W'(py));
    pending_counts.push_back(want);
  endtask

  task automatic wait_results_drained();
    start <= 1'b0;
    while (pending_counts.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic test_reset_defaults();
    send_pixel(IMG_W / 2, IMG_H / 2);
    send_pixel(0, 0);
    send_pixel(PIX_MAX, PIX_MAX);
    send_pixel(0, PIX_MAX);
    send_pixel(PIX_MAX, 0);
    wait_results_drained();
  endtask

  task automatic test_iteration_limits();
    load_julia('0, '0, DEF_STEP_X, DEF_STEP_Y, '0);
    send_pixel(IMG_W / 2, IMG_H / 2);
    send_pixel(100, 900);
    wait_results_drained();
    load_julia('0, '0, DEF_STEP_X, DEF_STEP_Y, 16'd1);
    send_pixel(IMG_W / 2, IMG_H / 2);
    send_pixel(0, 0);
    wait_results_drained();
    // origin never escapes with c = 0, so this word runs the full limit
    load_julia('0, '0, DEF_STEP_X, DEF_STEP_Y, '1);
    send_pixel(IMG_W / 2, IMG_H / 2);
    send_pixel(0, 0);
    wait_results_drained();
  endtask

  task automatic test_saturation();
    load_julia(32'sh7fff_ffff, 32'sh8000_0000, '1, '1, 16'd8);
    send_pixel(IMG_W / 2, IMG_H / 2);
    send_pixel(0, 0);
    send_pixel(PIX_MAX, PIX_MAX);
    send_pixel(IMG_W / 2 + 1, IMG_H / 2 - 1);
    wait_results_drained();
    load_julia(32'sh8000_0000, 32'sh7fff_ffff, '0, '0, 16'd16);
    send_pixel(0, PIX_MAX);
    send_pixel(PIX_MAX, 0);
    wait_results_drained();
    // zero step collapses every pixel onto the origin
    load_julia('0, '0, '0, '0, 16'd20);
    send_pixel(0, 0);
    send_pixel(PIX_MAX, PIX_MAX);
    wait_results_drained();
  endtask

  task automatic test_unknown_index();
    load_julia(32'shf400_0000, 32'sh0199_999a, DEF_STEP_X, DEF_STEP_Y, 16'd50);
    for (int i = int'(CFG_ITER_LIMIT) + 1; i < (1 << CFG_IDX_W); i++) begin
      write_reg(CFG_IDX_W'(i), $urandom);
    end
    send_pixel(IMG_W / 2, IMG_H / 2);
    send_pixel(300, 700);
    send_pixel(600, 400);
    wait_results_drained();
  endtask

  task automatic test_random_frames();
    logic signed [FIX_W-1:0] c_re;
    logic signed [FIX_W-1:0] c_im;
    logic [SCL_W-1:0]        sx;
    logic [SCL_W-1:0]        sy;
    logic [ITER_W-1:0]       limit;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p % 4)
        0: begin
          // c within +-2.0, view around the set
          c_re = int'($urandom_range(0, 32'h4000_0000)) - 32'sh2000_0000;
          c_im = int'($urandom_range(0, 32'h4000_0000)) - 32'sh2000_0000;
          sx = SCL_W'($urandom_range(262144, 1048576));
          sy = SCL_W'($urandom_range(262144, 1048576));
          limit = ITER_W'($urandom_range(1, 96));
        end
        1: begin
          // c within +-1.0 for long orbits
          c_re = int'($urandom_range(0, 32'h2000_0000)) - 32'sh1000_0000;
          c_im = int'($urandom_range(0, 32'h2000_0000)) - 32'sh1000_0000;
          sx = SCL_W'($urandom_range(786432, 1048576));
          sy = SCL_W'($urandom_range(524288, 1048576));
          limit = ITER_W'($urandom_range(32, 200));
        end
        2: begin
          c_re = $urandom;
          c_im = $urandom;
          sx = SCL_W'($urandom);
          sy = SCL_W'($urandom);
          limit = ($urandom_range(0, 7) == 0) ? '0 : ITER_W'($urandom_range(1, 64));
        end
        default: begin
          // deep zoom
          c_re = int'($urandom_range(0, 32'h2000_0000)) - 32'sh1000_0000;
          c_im = int'($urandom_range(0, 32'h2000_0000)) - 32'sh1000_0000;
          sx = SCL_W'($urandom_range(1, 8192));
          sy = SCL_W'($urandom_range(1, 8192));
          limit = ITER_W'($urandom_range(1, 128));
        end
      endcase
      load_julia(c_re, c_im, sx, sy, limit);
      idle_pct = (p == RANDOM_PHASES / 2) ? 0 : 11;
      for (int i = 0; i < WORDS_PER_PHASE; i++) begin
        if (p == RANDOM_PHASES - 3 && i == WORDS_PER_PHASE / 2) begin
          wait_results_drained();
        end
        send_pixel($urandom_range(0, PIX_MAX), $urandom_range(0, PIX_MAX));
      end
      wait_results_drained();
    end
    idle_pct = 11;
  endtask

  // result checker
  always @(posedge clk) begin
    pixel_count_t want;
    if (rst_n && out_valid) begin
      if (pending_counts.size() == 0) begin
        flag_error($sformatf("unexpected word x=%0d y=%0d iterations=%0d",
                             out_x, out_y, out_iterations));
      end else begin
        want = pending_counts.pop_front();
        if (out_x !== want.x || out_y !== want.y || out_iterations !== want.iters) begin
          flag_error($sformatf("expected x=%0d y=%0d iterations=%0d, got x=%0d y=%0d iterations=%0d",
                               want.x, want.y, want.iters, out_x, out_y, out_iterations));
        end
      end
    end
  end

  // watchdog on cycles with no word moving either way
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
      $display("julia_escape_time_core test failed");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_iteration_limits();
    test_saturation();
    test_unknown_index();
    test_random_frames();
    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_counts.size() != 0) begin
      flag_error($sformatf("%0d results never arrived", pending_counts.size()));
    end
    if (error_count == 0) begin
      $display("julia_escape_time_core test passed");
    end else begin
      $display("julia_escape_time_core test failed");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/jet_pkg.sv
hw/rtl/jet_queue.sv
hw/rtl/jet_front.sv
hw/rtl/jet_iter.sv
hw/rtl/julia_escape_time_core.sv
dv/julia_escape_time_core_tb.sv
